/* src/ccblit_pkg.sv */
// shared types and constants for the character-cell sprite blitter
// no dependencies; imported by the clip, screen memory and top-level modules
package ccblit_pkg;

    // signed working width of the clip arithmetic, enough for screens of up to 256 cells a side
    localparam int CLIP_W = 11;
    localparam int GLYPH_W = 16;

    // transparency key of sprite cells: a space
    localparam logic [GLYPH_W-1:0] KEY_GLYPH = 16'd32;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_BLIT  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLIP,
        ST_ACCESS,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]          cmd;
        logic signed [7:0]   pos_x;
        logic signed [7:0]   pos_y;
        logic [6:0]          sprite_width;
        logic [5:0]          sprite_height;
        logic [5:0]          start_col;
        logic [4:0]          start_row;
        logic [5:0]          col;
        logic [4:0]          row;
        logic [GLYPH_W-1:0]  glyph;
    } in_word_t;

    typedef struct packed {
        logic [GLYPH_W-1:0] read_glyph;
        logic               written;
    } out_word_t;

    // memory operation decided by the clip stage
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } acc_ctl_t;

endpackage

/* src/ccblit_stream_if.sv */
// valid/ready channel carrying one word per handshake
// payload type is given at instantiation (ccblit_pkg::in_word_t or out_word_t)
interface ccblit_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

/* src/ccblit_clip.sv */
// clip stage: maps a command word to a screen cell address and a memory operation
// depends on ccblit_pkg; results are registered for the memory access cycle
module ccblit_clip #(
    parameter int SCREEN_COLS = 64,
    parameter int SCREEN_ROWS = 32,
    parameter int ADDR_W = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  ccblit_pkg::in_word_t          word,
    output ccblit_pkg::acc_ctl_t          ctl_reg,
    output logic [ADDR_W-1:0]             addr_reg,
    output logic [ccblit_pkg::GLYPH_W-1:0] glyph_reg
);
    import ccblit_pkg::*;

    localparam int COL_W = $clog2(SCREEN_COLS);
    localparam int ROW_W = $clog2(SCREEN_ROWS);
    localparam logic signed [CLIP_W-1:0] COLS_S = CLIP_W'(SCREEN_COLS);
    localparam logic signed [CLIP_W-1:0] ROWS_S = CLIP_W'(SCREEN_ROWS);

    logic signed [CLIP_W-1:0] px, py, w, h, sx, sy, cc, rr;
    logic signed [CLIP_W-1:0] top, left, hgt, xend, sy_e, sx_e, j, k;
    logic signed [CLIP_W-1:0] scr_x, scr_y;
    logic                     vis, on_scr;
    acc_ctl_t                 ctl_next;
    logic [ADDR_W-1:0]        addr_next;

    always_comb
    begin
        px = {{(CLIP_W-8){word.pos_x[7]}}, word.pos_x};
        py = {{(CLIP_W-8){word.pos_y[7]}}, word.pos_y};
        w  = {{(CLIP_W-7){1'b0}}, word.sprite_width};
        h  = {{(CLIP_W-6){1'b0}}, word.sprite_height};
        sx = {{(CLIP_W-6){1'b0}}, word.start_col};
        sy = {{(CLIP_W-5){1'b0}}, word.start_row};
        cc = {{(CLIP_W-6){1'b0}}, word.col};
        rr = {{(CLIP_W-5){1'b0}}, word.row};

        // top clip replaces the start row with the clipped row count; else the height is cut at the bottom edge
        if (py[CLIP_W-1])
        begin
            top  = '0;
            sy_e = -py;
            hgt  = h + py;
        end
        else
        begin
            top  = py;
            sy_e = sy;
            hgt  = (py + h > ROWS_S) ? (ROWS_S - py) : h;
        end

        if (px[CLIP_W-1])
        begin
            left = '0;
            sx_e = -px;
            xend = w + px;
        end
        else
        begin
            left = px;
            sx_e = sx;
            xend = (px + w > COLS_S) ? COLS_S : (px + w);
        end

        j = top + rr - sy_e;
        k = left + cc - sx_e;

        vis = (j >= top) && (j < top + hgt) && (k >= left) && (k < xend) &&
              !k[CLIP_W-1] && (k < COLS_S) && !j[CLIP_W-1] && (j < ROWS_S) &&
              (word.glyph != KEY_GLYPH);
        on_scr = (cc < COLS_S) && (rr < ROWS_S);

        if (word.cmd == CMD_BLIT)
        begin
            scr_x = k;
            scr_y = j;
        end
        else
        begin
            scr_x = cc;
            scr_y = rr;
        end

        ctl_next.wr_en = ((word.cmd == CMD_WRITE) && on_scr) || ((word.cmd == CMD_BLIT) && vis);
        ctl_next.rd_en = (word.cmd == CMD_READ) && on_scr;

        addr_next = ADDR_W'(scr_y[ROW_W-1:0]) * ADDR_W'(SCREEN_COLS)
                  + ADDR_W'(scr_x[COL_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (load)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg  <= addr_next;
            glyph_reg <= word.glyph;
        end
    end

endmodule

/* src/ccblit_screen_mem.sv */
// screen cell store: single-port synchronous memory, registered read
// depends on ccblit_pkg for the glyph width
module ccblit_screen_mem #(
    parameter int DEPTH = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic                           rd_en,
    input  logic [ADDR_W-1:0]              addr,
    input  logic [ccblit_pkg::GLYPH_W-1:0] wdata,
    output logic [ccblit_pkg::GLYPH_W-1:0] rdata_reg
);
    import ccblit_pkg::*;

    logic [GLYPH_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

endmodule

/* src/char_cell_sprite_blitter_unit.sv */
// Character-cell framebuffer with a sprite blitter. Each word on item is a background
// write, one sprite cell blit (clipped against the screen, spaces transparent), a cell
// read or no operation; each gives exactly one word on result. An accepted item is
// captured, then its clip compare and address are registered, then the screen memory is
// accessed, then the result is registered. The block takes one word at a time: no new
// item is accepted until the last one's result is registered, and a result word still
// waiting in the output register holds the last step. The screen store has no reset;
// a cell must be written before it is read.
// depends on ccblit_pkg, ccblit_stream_if, ccblit_clip, ccblit_screen_mem
module char_cell_sprite_blitter_unit #(
    parameter int SCREEN_COLS = 64,
    parameter int SCREEN_ROWS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    ccblit_stream_if.sink          item,
    ccblit_stream_if.source        result
);
    import ccblit_pkg::*;

    localparam int DEPTH  = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    state_t             state_reg, state_next;
    in_word_t           item_reg;
    out_word_t          out_word_reg;
    logic               out_valid_reg, out_valid_next;
    acc_ctl_t           ctl;
    logic [ADDR_W-1:0]  addr;
    logic [GLYPH_W-1:0] glyph;
    logic [GLYPH_W-1:0] rdata;
    logic               accept, clip_load, mem_go, out_load;

    assign accept = item.valid && item.ready;

    ccblit_clip #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .ADDR_W      (ADDR_W)
    ) u_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (clip_load),
        .word      (item_reg),
        .ctl_reg   (ctl),
        .addr_reg  (addr),
        .glyph_reg (glyph)
    );

    ccblit_screen_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk       (clk),
        .wr_en     (mem_go && ctl.wr_en),
        .rd_en     (mem_go && ctl.rd_en),
        .addr      (addr),
        .wdata     (glyph),
        .rdata_reg (rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = ST_CLIP;
                end
            end
            ST_CLIP:   state_next = ST_ACCESS;
            ST_ACCESS: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        item.ready = 1'b0;
        clip_load  = 1'b0;
        mem_go     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:   item.ready = 1'b1;
            ST_CLIP:   clip_load  = 1'b1;
            ST_ACCESS: mem_go     = 1'b1;
            ST_FINISH: out_load   = !out_valid_reg || result.ready;
            default:   item.ready = 1'b0;
        endcase
    end

    // output register frees itself when taken, refills on a finished item
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item.payload;
        end
        if (out_load)
        begin
            out_word_reg.read_glyph <= ctl.rd_en ? rdata : '0;
            out_word_reg.written    <= ctl.wr_en;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_word_reg;

endmodule

/* src/ccblit_checker.sv */
// port-level checks of the sprite blitter, bound to the top level
// depends on char_cell_sprite_blitter_unit and its interface ports
module ccblit_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [15:0] result_glyph,
    input logic        result_written
);

    // a finished word is held until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped before it was taken");

    // one item at a time: no new word while the last one is in the clip, access and finish states
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready ##1 !item_ready ##1 !item_ready)
        else $error("item accepted while the previous one is in flight");

    // a write never returns read data
    a_write_no_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_written |-> result_glyph == 16'd0)
        else $error("result reports both a write and read data");

    // a fresh result comes from the last accepted item, through the clip, access and finish states
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 4))
        else $error("result word without a matching accepted item");

endmodule

bind char_cell_sprite_blitter_unit ccblit_checker u_ccblit_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_glyph   (result.payload.read_glyph),
    .result_written (result.payload.written)
);
